/* src/dsbk_pkg.sv */
`timescale 1ns / 1ps

package dsbk_pkg;

   // digits that appear in the key
   localparam int KEY_OUT_DIGITS     = 20;
   localparam int KEY_DIGITS_DEFAULT = 20;
   localparam int NIB_W              = 4;

   // ascii codes the parser reacts to
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [7:0] ASCII_DOT   = 8'h2E;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;

   // key byte constants
   localparam logic [7:0] SIG_OFFSET = 8'd52;
   localparam logic [4:0] EDC_MAX    = 5'd31;
   localparam logic [7:0] ENC_MARK   = 8'h01;
   localparam logic [7:0] ENC_SIGN   = 8'h80;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0]  sig_byte;
      logic [7:0]  enc_byte;
      logic [63:0] digits_high;
      logic [15:0] digits_low;
   } rsp_type;

endpackage

/* src/decimal_string_to_bcd_key.sv */
`timescale 1ns / 1ps

// decimal string to packed bcd index key
//
// req channel: one ascii character per word (req_data.char_in), with
// req_data.last set on the final character of a number. rsp channel: one
// 12-byte key word (significance byte, encoded count byte, 20 bcd digits)
// per number, produced only for the word marked last.
//
// the key appears on rsp_valid in the cycle after the last character is
// accepted. throughput: one character per cycle while req_ready is high; the
// parser updates its counters and writes at most one digit nibble per accepted word.
//
// the key sits in an output register. req_ready stays high while that
// register is empty or being drained, so a stalled receiver only holds up
// the input once a finished key is waiting and not taken.
//
// reset (synchronous, active high) empties the output register and puts
// the parser in its leading-space phase with all counters and digits zero.
// the parser returns to that same state after every last character.

module decimal_string_to_bcd_key #(
   parameter int KEY_DIGITS = dsbk_pkg::KEY_DIGITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dsbk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dsbk_pkg::rsp_type rsp_data
);

   // only the first KEY_OUT_DIGITS stored digits can reach the key, so the
   // buffer holds no more than that
   localparam int BUF_N = (KEY_DIGITS < dsbk_pkg::KEY_OUT_DIGITS) ?
                          KEY_DIGITS : dsbk_pkg::KEY_OUT_DIGITS;
   localparam int CNT_W = $clog2(BUF_N + 1);
   localparam int IDX_W = $clog2(BUF_N);
   localparam int KEY_W = dsbk_pkg::KEY_OUT_DIGITS * dsbk_pkg::NIB_W;

   typedef enum logic [2:0] {
      PH_LEAD,      // skipping leading spaces
      PH_SIGN,      // minus seen
      PH_ZERO,      // dropping leading integer zeros
      PH_INT,       // integer digits
      PH_FRACLEAD,  // fraction zeros after a leading dot
      PH_FRAC,      // fraction digits
      PH_TRAIL      // number ended, ignore the rest
   } phase_type;

   // parser state
   phase_type  phase_ff, phase_in;
   logic       neg_ff, neg_in;
   logic [7:0] int_count_ff, int_count_in;   // wraps
   logic [7:0] int_sat_ff, int_sat_in;       // saturates
   logic [7:0] flz_ff, flz_in;               // leading fraction zeros, wraps
   logic [7:0] frac_count_ff, frac_count_in; // saturates
   logic [7:0] fnl_ff, fnl_in;               // fraction length to last nonzero
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic [dsbk_pkg::NIB_W-1:0] nib_ff [BUF_N];
   logic [dsbk_pkg::NIB_W-1:0] nib_in [BUF_N];

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   dsbk_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       accept;
   logic [7:0] ch;
   logic       is_digit;
   logic [dsbk_pkg::NIB_W-1:0] dig;
   logic       store_en;
   logic [7:0] frac_count_inc;

   logic [8:0]       edc_sum;
   logic [4:0]       edc;
   logic [7:0]       sig_sub;
   logic [KEY_W-1:0] key_digits;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ch       = req_data.char_in;
   assign is_digit = (ch >= dsbk_pkg::ASCII_ZERO) && (ch <= dsbk_pkg::ASCII_NINE);
   // '0'..'9' carry the digit value in the low nibble
   assign dig      = ch[dsbk_pkg::NIB_W-1:0];
   assign frac_count_inc = (frac_count_ff == 8'hFF) ? frac_count_ff : frac_count_ff + 8'd1;

   // character parser: next state for this word
   always_comb begin
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      int_count_in  = int_count_ff;
      int_sat_in    = int_sat_ff;
      flz_in        = flz_ff;
      frac_count_in = frac_count_ff;
      fnl_in        = fnl_ff;
      store_en      = 1'b0;

      priority if (phase_ff == PH_TRAIL) begin
         // everything after the number is ignored
      end else if (ch == dsbk_pkg::ASCII_SPACE) begin
         if (phase_ff != PH_LEAD) begin
            phase_in = PH_TRAIL;
         end
      end else if (ch == dsbk_pkg::ASCII_MINUS) begin
         if (phase_ff == PH_LEAD) begin
            neg_in   = 1'b1;
            phase_in = PH_SIGN;
         end
      end else if (ch == dsbk_pkg::ASCII_DOT) begin
         if (phase_ff == PH_LEAD || phase_ff == PH_SIGN || phase_ff == PH_ZERO) begin
            phase_in = PH_FRACLEAD;
         end else if (phase_ff == PH_INT) begin
            phase_in = PH_FRAC;
         end
      end else if (is_digit) begin
         unique case (phase_ff)
            PH_LEAD, PH_SIGN, PH_ZERO: begin
               if (dig == '0) begin
                  phase_in = PH_ZERO;
               end else begin
                  int_count_in = int_count_ff + 8'd1;
                  int_sat_in   = (int_sat_ff == 8'hFF) ? int_sat_ff : int_sat_ff + 8'd1;
                  store_en     = 1'b1;
                  phase_in     = PH_INT;
               end
            end
            PH_INT: begin
               int_count_in = int_count_ff + 8'd1;
               int_sat_in   = (int_sat_ff == 8'hFF) ? int_sat_ff : int_sat_ff + 8'd1;
               store_en     = 1'b1;
            end
            PH_FRACLEAD: begin
               frac_count_in = frac_count_inc;
               if (dig == '0) begin
                  flz_in = flz_ff + 8'd1;
               end else begin
                  fnl_in   = frac_count_inc;
                  store_en = 1'b1;
                  phase_in = PH_FRAC;
               end
            end
            PH_FRAC: begin
               frac_count_in = frac_count_inc;
               store_en      = 1'b1;
               if (dig != '0) begin
                  fnl_in = frac_count_inc;
               end
            end
            default: begin
            end
         endcase
      end else begin
         // any other character is dropped
      end
   end

   // digit buffer write, at most one nibble per word
   always_comb begin
      stored_in = stored_ff;
      for (int i = 0; i < BUF_N; i++) begin
         nib_in[i] = nib_ff[i];
      end
      if (store_en && (stored_ff < CNT_W'(BUF_N))) begin
         nib_in[stored_ff[IDX_W-1:0]] = dig;
         stored_in = stored_ff + CNT_W'(1);
      end
   end

   // key assembly from the state after this word
   always_comb begin
      edc_sum = {1'b0, int_sat_in} + {1'b0, fnl_in};
      edc     = (edc_sum > {4'd0, dsbk_pkg::EDC_MAX}) ? dsbk_pkg::EDC_MAX : edc_sum[4:0];
      // leading fraction zeros only count once a nonzero fraction digit shows up
      sig_sub = (fnl_in != 8'd0) ? flz_in : 8'd0;

      key_digits = '0;
      for (int i = 0; i < BUF_N; i++) begin
         key_digits[KEY_W-1-dsbk_pkg::NIB_W*i -: dsbk_pkg::NIB_W] = nib_in[i];
      end

      rsp_data_in.sig_byte    = int_count_in + dsbk_pkg::SIG_OFFSET - sig_sub;
      rsp_data_in.enc_byte    = (neg_in ? dsbk_pkg::ENC_SIGN : 8'h00) |
                                {1'b0, edc, 2'b00} | dsbk_pkg::ENC_MARK;
      rsp_data_in.digits_high = key_digits[KEY_W-1 -: 64];
      rsp_data_in.digits_low  = key_digits[15:0];
   end

   // output register: loaded by a last word, emptied when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && req_data.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD;
         neg_ff        <= 1'b0;
         int_count_ff  <= '0;
         int_sat_ff    <= '0;
         flz_ff        <= '0;
         frac_count_ff <= '0;
         fnl_ff        <= '0;
         stored_ff     <= '0;
         for (int i = 0; i < BUF_N; i++) begin
            nib_ff[i] <= '0;
         end
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_data.last) begin
               // key goes out, parser starts over
               rsp_data_ff   <= rsp_data_in;
               phase_ff      <= PH_LEAD;
               neg_ff        <= 1'b0;
               int_count_ff  <= '0;
               int_sat_ff    <= '0;
               flz_ff        <= '0;
               frac_count_ff <= '0;
               fnl_ff        <= '0;
               stored_ff     <= '0;
               for (int i = 0; i < BUF_N; i++) begin
                  nib_ff[i] <= '0;
               end
            end else begin
               phase_ff      <= phase_in;
               neg_ff        <= neg_in;
               int_count_ff  <= int_count_in;
               int_sat_ff    <= int_sat_in;
               flz_ff        <= flz_in;
               frac_count_ff <= frac_count_in;
               fnl_ff        <= fnl_in;
               stored_ff     <= stored_in;
               for (int i = 0; i < BUF_N; i++) begin
                  nib_ff[i] <= nib_in[i];
               end
            end
         end
      end
   end

   // a last word always leaves a key in the output register
   a_last_gives_key: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last) |=> rsp_valid)
      else $error("key missing after last word");

   // a plain word never creates a key out of an empty or drained register
   a_no_spurious_key: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_data.last && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid)
      else $error("key produced without a last word");

   // parser is back at its start after a key
   a_parser_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last) |=> (phase_ff == PH_LEAD && stored_ff == '0 && !neg_ff))
      else $error("parser not restarted after key");

   // count byte always carries its marker bit and a clear bit 1
   a_enc_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.enc_byte[0] && !rsp_data.enc_byte[1]))
      else $error("encoded count byte malformed");

   // digit count never runs past the buffer
   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CNT_W'(BUF_N))
      else $error("digit count past buffer");

endmodule

/* bench/decimal_string_to_bcd_key_tb.sv */
`timescale 1ns / 1ps

module decimal_string_to_bcd_key_tb;

   // stimulus size and timing limits
   localparam int WORD_TARGET     = 1150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 5000;

   // predicts the key of each number from its characters and keeps the
   // keys that are still owed by the block, oldest first
   class key_scoreboard_type;
      typedef enum logic [2:0] {
         SCAN_LEAD,
         SCAN_SIGN,
         SCAN_ZERO,
         SCAN_INT,
         SCAN_FRAC_LEAD,
         SCAN_FRAC,
         SCAN_TRAIL
      } scan_phase_type;

      localparam int STORE_DIGITS =
         (dsbk_pkg::KEY_DIGITS_DEFAULT < dsbk_pkg::KEY_OUT_DIGITS) ?
         dsbk_pkg::KEY_DIGITS_DEFAULT : dsbk_pkg::KEY_OUT_DIGITS;

      scan_phase_type    phase;
      bit                negative;
      logic [7:0]        int_count;
      logic [7:0]        int_sat;
      logic [7:0]        lead_zeros;
      logic [7:0]        frac_count;
      logic [7:0]        frac_last_nz;
      int                nibbles;
      logic [3:0]        digit_buf [dsbk_pkg::KEY_OUT_DIGITS];
      dsbk_pkg::rsp_type pending_keys [$];
      int                errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         phase        = SCAN_LEAD;
         negative     = 1'b0;
         int_count    = '0;
         int_sat      = '0;
         lead_zeros   = '0;
         frac_count   = '0;
         frac_last_nz = '0;
         nibbles      = 0;
         foreach (digit_buf[i]) digit_buf[i] = '0;
      endfunction

      task report_mismatch(string msg);
         $display("key mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      function void store_digit(logic [3:0] d);
         if (nibbles < STORE_DIGITS) begin
            digit_buf[nibbles] = d;
            nibbles++;
         end
      endfunction

      // integer digit: wrapping count for the significance byte, saturating
      // count for the encoded digit count
      function void take_int(logic [3:0] d);
         int_count = int_count + 8'd1;
         if (int_sat != 8'hFF) int_sat = int_sat + 8'd1;
         store_digit(d);
      endfunction

      function void note_char(dsbk_pkg::req_type w);
         logic [7:0]        c;
         logic [3:0]        d;
         logic [8:0]        count_sum;
         logic [4:0]        enc_count;
         dsbk_pkg::rsp_type want;
         c = w.char_in;
         d = c[3:0];
         // once a space has ended the number nothing else is taken in
         if (phase != SCAN_TRAIL) begin
            if (c == dsbk_pkg::ASCII_SPACE) begin
               if (phase != SCAN_LEAD) phase = SCAN_TRAIL;
            end else if (c == dsbk_pkg::ASCII_MINUS) begin
               // only a minus in leading position gives the sign
               if (phase == SCAN_LEAD) begin
                  negative = 1'b1;
                  phase    = SCAN_SIGN;
               end
            end else if (c == dsbk_pkg::ASCII_DOT) begin
               if (phase == SCAN_LEAD || phase == SCAN_SIGN || phase == SCAN_ZERO) begin
                  phase = SCAN_FRAC_LEAD;
               end else if (phase == SCAN_INT) begin
                  phase = SCAN_FRAC;
               end
            end else if (c >= dsbk_pkg::ASCII_ZERO && c <= dsbk_pkg::ASCII_NINE) begin
               case (phase)
                  SCAN_LEAD, SCAN_SIGN, SCAN_ZERO: begin
                     if (d == 4'd0) begin
                        phase = SCAN_ZERO;
                     end else begin
                        take_int(d);
                        phase = SCAN_INT;
                     end
                  end
                  SCAN_INT: take_int(d);
                  SCAN_FRAC_LEAD: begin
                     if (frac_count != 8'hFF) frac_count = frac_count + 8'd1;
                     // zeros after a leading dot are counted, not stored
                     if (d == 4'd0) begin
                        lead_zeros = lead_zeros + 8'd1;
                     end else begin
                        frac_last_nz = frac_count;
                        store_digit(d);
                        phase = SCAN_FRAC;
                     end
                  end
                  default: begin
                     if (frac_count != 8'hFF) frac_count = frac_count + 8'd1;
                     store_digit(d);
                     if (d != 4'd0) frac_last_nz = frac_count;
                  end
               endcase
            end
         end

         if (w.last) begin
            count_sum = {1'b0, int_sat} + {1'b0, frac_last_nz};
            enc_count = (count_sum > 9'(dsbk_pkg::EDC_MAX)) ?
                        dsbk_pkg::EDC_MAX : count_sum[4:0];
            want.sig_byte = int_count + dsbk_pkg::SIG_OFFSET;
            // leading fraction zeros only lower the byte once a nonzero
            // fraction digit has come
            if (frac_last_nz != 8'd0) want.sig_byte = want.sig_byte - lead_zeros;
            want.enc_byte = dsbk_pkg::ENC_MARK | {1'b0, enc_count, 2'b00};
            if (negative) want.enc_byte = want.enc_byte | dsbk_pkg::ENC_SIGN;
            want.digits_high = '0;
            want.digits_low  = '0;
            for (int i = 0; i < 16; i++) want.digits_high[63 - 4*i -: 4] = digit_buf[i];
            for (int i = 0; i < 4; i++) want.digits_low[15 - 4*i -: 4] = digit_buf[16 + i];
            pending_keys.push_back(want);
            clear();
         end
      endfunction

      task check_key(dsbk_pkg::rsp_type got);
         dsbk_pkg::rsp_type want;
         if (pending_keys.size() == 0) begin
            report_mismatch($sformatf("key %h with no number pending", got));
         end else begin
            want = pending_keys.pop_front();
            if (got.sig_byte !== want.sig_byte)
               report_mismatch($sformatf("sig_byte got %h want %h",
                                         got.sig_byte, want.sig_byte));
            if (got.enc_byte !== want.enc_byte)
               report_mismatch($sformatf("enc_byte got %h want %h",
                                         got.enc_byte, want.enc_byte));
            if (got.digits_high !== want.digits_high)
               report_mismatch($sformatf("digits_high got %h want %h",
                                         got.digits_high, want.digits_high));
            if (got.digits_low !== want.digits_low)
               report_mismatch($sformatf("digits_low got %h want %h",
                                         got.digits_low, want.digits_low));
         end
      endtask

      function int pending();
         return pending_keys.size();
      endfunction

      task flush_leftover();
         while (pending_keys.size() != 0)
            report_mismatch($sformatf("key %h never arrived", pending_keys.pop_front()));
      endtask
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dsbk_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dsbk_pkg::rsp_type rsp_data;

   key_scoreboard_type keys = new();

   int words_sent   = 0;
   bit sender_fast  = 1'b0;
   bit hold_off_req = 1'b0;

   always #5 clock = ~clock;

   decimal_string_to_bcd_key u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // idle length: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // offer one character word and hold it until the block takes it; valid
   // stays high straight into the next word when there is no gap
   task automatic send_word(input logic [7:0] ch, input logic is_last);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{char_in: ch, last: is_last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      keys.note_char(req_data);
      words_sent++;
      gap = sender_fast ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
   endtask

   task automatic send_chars(input byte unsigned chars [$]);
      foreach (chars[i]) send_word(chars[i], i == chars.size() - 1);
   endtask

   // receiver: random stalls, bursts of steady ready, and one long hold-off
   // on request so that a finished key blocks the input side
   initial begin : rsp_side
      int stall_left;
      int burst_left;
      stall_left = 0;
      burst_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) keys.check_key(rsp_data);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
            burst_left   = 0;
         end
         if (stall_left == 0 && burst_left == 0) begin
            if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(50, 200);
            else stall_left = gap_len();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (burst_left > 0) burst_left--;
         end
      end
   end

   // ends the run when neither channel has moved a word for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("decimal_string_to_bcd_key_tb: errors");
      $finish;
   end

   initial begin : req_side
      byte unsigned chars [$];
      int           number_idx;
      int           k;
      int           r;
      number_idx = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty signed number, repeated minus, leading dot zeros,
      // all-zero fraction, misplaced minus and second dot, space ending the
      // number, and ignored bytes at both ends of the code range
      send_text(" -0");
      send_text("--5");
      send_text(".007");
      send_text("10.0");
      send_text("3.2-.1");
      send_text("8 7");
      send_word(8'hFF, 1'b0);
      send_word(dsbk_pkg::ASCII_NINE, 1'b0);
      send_word(8'h00, 1'b1);

      // long integer: significance byte wraps, digits overflow, count saturates
      chars.delete();
      chars.push_back(dsbk_pkg::ASCII_MINUS);
      chars.push_back(8'(dsbk_pkg::ASCII_ZERO + $urandom_range(1, 9)));
      repeat (210) chars.push_back(8'(dsbk_pkg::ASCII_ZERO + $urandom_range(0, 9)));
      send_chars(chars);

      // long leading-dot fraction: zero count wraps, fraction count saturates
      chars.delete();
      chars.push_back(dsbk_pkg::ASCII_DOT);
      repeat (258) chars.push_back(dsbk_pkg::ASCII_ZERO);
      chars.push_back(8'(dsbk_pkg::ASCII_ZERO + $urandom_range(1, 9)));
      send_chars(chars);

      while (words_sent < WORD_TARGET) begin
         chars.delete();
         sender_fast = ($urandom_range(0, 4) == 0);
         if (number_idx == 25) begin
            // receiver holds off while numbers keep coming back to back
            hold_off_req = 1'b1;
            sender_fast  = 1'b1;
         end
         if (number_idx == 60) begin
            // pause until the block has handed over every key
            req_valid <= 1'b0;
            while (keys.pending() != 0) @(posedge clock);
         end

         r = $urandom_range(0, 99);
         if (r < 70) begin
            // well-formed number with random shape and content
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) chars.push_back(dsbk_pkg::ASCII_SPACE);
            if ($urandom_range(0, 1) == 1) begin
               chars.push_back(dsbk_pkg::ASCII_MINUS);
               if ($urandom_range(0, 7) == 0) chars.push_back(dsbk_pkg::ASCII_MINUS);
            end
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) chars.push_back(dsbk_pkg::ASCII_ZERO);
            k = $urandom_range(0, 19);
            k = (k < 3) ? 0 : (k < 17) ? $urandom_range(1, 6) : $urandom_range(15, 34);
            if (k > 0) chars.push_back(8'(dsbk_pkg::ASCII_ZERO + $urandom_range(1, 9)));
            for (int i = 1; i < k; i++)
               chars.push_back(8'(dsbk_pkg::ASCII_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 2) != 0) begin
               chars.push_back(dsbk_pkg::ASCII_DOT);
               if ($urandom_range(0, 19) == 0) k = $urandom_range(40, 70);
               else k = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 3) : 0;
               repeat (k) chars.push_back(dsbk_pkg::ASCII_ZERO);
               repeat ($urandom_range(0, 6))
                  chars.push_back(8'(dsbk_pkg::ASCII_ZERO + $urandom_range(0, 9)));
               if ($urandom_range(0, 3) == 0)
                  repeat ($urandom_range(1, 3)) chars.push_back(dsbk_pkg::ASCII_ZERO);
            end
            if ($urandom_range(0, 4) == 0) begin
               chars.push_back(dsbk_pkg::ASCII_SPACE);
               repeat ($urandom_range(0, 3)) chars.push_back(8'($urandom_range(0, 255)));
            end
         end else if (r < 85) begin
            // noise over the whole byte range
            repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
         end else begin
            // broken sequences of the characters the parser reacts to
            repeat ($urandom_range(1, 10)) begin
               case ($urandom_range(0, 4))
                  0: chars.push_back(dsbk_pkg::ASCII_DOT);
                  1: chars.push_back(dsbk_pkg::ASCII_MINUS);
                  2: chars.push_back(dsbk_pkg::ASCII_SPACE);
                  3: chars.push_back(8'($urandom_range(0, 255)));
                  default: chars.push_back(8'(dsbk_pkg::ASCII_ZERO + $urandom_range(0, 9)));
               endcase
            end
         end
         if (chars.size() == 0) chars.push_back(dsbk_pkg::ASCII_SPACE);
         send_chars(chars);
         number_idx++;
      end

      req_valid <= 1'b0;
      while (keys.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      keys.flush_leftover();
      if (keys.errors == 0) begin
         $display("decimal_string_to_bcd_key_tb: clean");
      end else begin
         $display("decimal_string_to_bcd_key_tb: errors");
      end
      $finish;
   end

endmodule

/* decimal_string_to_bcd_key.f */
src/dsbk_pkg.sv
src/decimal_string_to_bcd_key.sv
bench/decimal_string_to_bcd_key_tb.sv
